// ===== hw/rtl/wbos_pkg.sv =====
package wbos_pkg;

    // search geometry
    localparam int OVERLAP_FRAMES = 256;
    localparam int WINDOW_FRAMES  = 1024;
    localparam int SEARCH_RADIUS  = 256;
    localparam int COARSE_STRIDE  = 4;
    localparam int TOP_COUNT      = 4;
    localparam int SOURCE_FRAMES  = 4096;
    localparam int TAIL_CAP       = 256;

    // store geometry, two channel slots per frame
    localparam int TAIL_DEPTH = TAIL_CAP * 2;
    localparam int SRC_DEPTH  = SOURCE_FRAMES * 2;
    localparam int TAIL_AW    = $clog2(TAIL_DEPTH);
    localparam int SRC_AW     = $clog2(SRC_DEPTH);
    localparam int TAIL_FW    = $clog2(TAIL_CAP);

    // field widths
    localparam int MODE_W   = 2;
    localparam int OFF_W    = 12;
    localparam int SF_W     = 13;
    localparam int TF_W     = 9;
    localparam int SMP_W    = 16;
    localparam int CC_W     = 2;

    // arithmetic widths
    localparam int PROD_W   = 32;
    localparam int CORR_W   = 41;
    localparam int NORM_W   = 40;
    localparam int SCORE_W  = 40;
    localparam int SQ_W     = 80;
    localparam int HALF_W   = 20;
    localparam int IDX_W    = $clog2(OVERLAP_FRAMES + COARSE_STRIDE);
    localparam int STRIDE_W = $clog2(COARSE_STRIDE + 1);
    localparam int USED_W   = $clog2(TOP_COUNT + 1);
    localparam int TOPI_W   = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int DIVC_W   = $clog2(SQ_W);

    localparam logic [NORM_W-1:0] NORM_MIN = NORM_W'(2);
    localparam logic [CC_W-1:0]   CC_RESET = CC_W'(2);

    typedef enum logic [MODE_W-1:0] {
        MODE_TAIL   = 2'd0,
        MODE_SRC    = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic              start;
        logic [OFF_W-1:0]  off;
        logic              coarse;
        logic [SF_W-1:0]   sf;
        logic [TF_W-1:0]   tf;
        logic              stereo;
    } t_score_cmd;

    typedef struct packed {
        logic               done;
        logic [SCORE_W-1:0] score;
    } t_score_sts;

    typedef struct packed {
        logic              tail_we;
        logic              src_we;
        logic [TAIL_AW-1:0] tail_addr;
        logic [SRC_AW-1:0]  src_addr;
        logic [SMP_W-1:0]   data;
    } t_load;

endpackage

// ===== hw/rtl/wbos_if.sv =====
interface wbos_in_if import wbos_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [OFF_W-1:0]  frame_index;
    logic              channel_index;
    logic signed [SMP_W-1:0] sample;
    logic [OFF_W-1:0]  expected_offset;
    logic [SF_W-1:0]   source_frames;
    logic [TF_W-1:0]   tail_len;

    modport source (output valid, mode, frame_index, channel_index, sample,
                    expected_offset, source_frames, tail_len, input ready);
    modport sink   (input valid, mode, frame_index, channel_index, sample,
                    expected_offset, source_frames, tail_len, output ready);
endinterface

interface wbos_out_if import wbos_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] best_offset;

    modport source (output valid, best_offset, input ready);
    modport sink   (input valid, best_offset, output ready);
endinterface

// ===== hw/rtl/wbos_score.sv =====
module wbos_score import wbos_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_load      i_load,
    input  t_score_cmd i_cmd,
    output t_score_sts o_sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_DRAIN, S_CHECK, S_SQ, S_DIV, S_DONE
    } t_state;

    logic signed [SMP_W-1:0] r_tail_mem [TAIL_DEPTH];
    logic signed [SMP_W-1:0] r_src_mem  [SRC_DEPTH];

    t_state               r_state;
    logic [OFF_W-1:0]     r_off;
    logic [STRIDE_W-1:0]  r_stride;
    logic                 r_stereo;
    logic [IDX_W-1:0]     r_i;
    logic                 r_k;
    logic [IDX_W-1:0]     r_n;
    logic                 r_v1, r_v2;
    logic signed [SMP_W-1:0] r_t_q, r_s_q;
    logic signed [PROD_W-1:0] r_pc;
    logic [PROD_W-1:0]    r_pn;
    logic signed [CORR_W-1:0] r_corr;
    logic [NORM_W-1:0]    r_norm;
    logic [1:0]           r_sq_step;
    logic [2*HALF_W-1:0]  r_pp;
    logic [SQ_W-1:0]      r_sq;
    logic [NORM_W-1:0]    r_rem;
    logic [SCORE_W-1:0]   r_q;
    logic [DIVC_W-1:0]    r_div_cnt;
    logic [SCORE_W-1:0]   r_score;

    logic [TAIL_AW-1:0]   tail_rd;
    logic [SRC_AW-1:0]    src_rd;
    logic [OFF_W-1:0]     src_frame;
    logic [SF_W-1:0]      src_left;
    logic [IDX_W-1:0]     n_n;
    logic                 last_issue;
    logic [HALF_W-1:0]    mul_a, mul_b;
    logic [2*HALF_W-1:0]  mul_p;
    logic [SQ_W-1:0]      sq_add;
    logic [NORM_W:0]      rem_sh;
    logic                 q_bit;

    // memory write ports (sample loads) and registered read ports
    always_ff @(posedge i_clk) begin
        if (i_load.tail_we) begin
            r_tail_mem[i_load.tail_addr] <= i_load.data;
        end
        r_t_q <= r_tail_mem[tail_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_load.src_we) begin
            r_src_mem[i_load.src_addr] <= i_load.data;
        end
        r_s_q <= r_src_mem[src_rd];
    end

    always_comb begin
        src_frame  = r_off + OFF_W'(r_i);
        tail_rd    = {r_i[TAIL_FW-1:0], r_k};
        src_rd     = {src_frame, r_k};
        last_issue = (!r_stereo || r_k) &&
                     ((r_i + IDX_W'(r_stride)) >= r_n);
        // n = min(overlap, tail frames, frames left after the offset)
        src_left   = i_cmd.sf - SF_W'(i_cmd.off);
        n_n        = IDX_W'(OVERLAP_FRAMES);
        if (IDX_W'(i_cmd.tf) < n_n) begin
            n_n = IDX_W'(i_cmd.tf);
        end
        if (src_left < SF_W'(n_n)) begin
            n_n = IDX_W'(src_left);
        end
    end

    // square of corr from 20-bit halves, one partial product a cycle
    always_comb begin
        mul_a = r_corr[HALF_W-1:0];
        mul_b = r_corr[HALF_W-1:0];
        case (r_sq_step)
            2'd0: begin
                mul_a = r_corr[HALF_W-1:0];
                mul_b = r_corr[HALF_W-1:0];
            end
            2'd1: begin
                mul_a = r_corr[2*HALF_W-1:HALF_W];
                mul_b = r_corr[HALF_W-1:0];
            end
            2'd2: begin
                mul_a = r_corr[2*HALF_W-1:HALF_W];
                mul_b = r_corr[2*HALF_W-1:HALF_W];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
        case (r_sq_step)
            2'd1:    sq_add = SQ_W'(r_pp);
            2'd2:    sq_add = SQ_W'(r_pp) << (HALF_W + 1);
            2'd3:    sq_add = SQ_W'(r_pp) << (2 * HALF_W);
            default: sq_add = '0;
        endcase
    end

    always_comb begin
        rem_sh = {r_rem, r_sq[SQ_W-1]};
        q_bit  = rem_sh >= {1'b0, r_norm};
    end

    always_ff @(posedge i_clk) begin
        r_pc <= PROD_W'(r_t_q * r_s_q);
        r_pn <= PROD_W'(r_s_q * r_s_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
            if (r_v2) begin
                r_corr <= r_corr + CORR_W'(r_pc);
                r_norm <= r_norm + NORM_W'(r_pn);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_off    <= i_cmd.off;
                        r_stride <= i_cmd.coarse ? STRIDE_W'(COARSE_STRIDE)
                                                 : STRIDE_W'(1);
                        r_stereo <= i_cmd.stereo;
                        r_i      <= '0;
                        r_k      <= 1'b0;
                        r_n      <= n_n;
                        r_corr   <= '0;
                        r_norm   <= '0;
                        r_score  <= '0;
                        r_state  <= (n_n == '0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    if (last_issue) begin
                        r_state <= S_DRAIN;
                    end else if (r_stereo && !r_k) begin
                        r_k <= 1'b1;
                    end else begin
                        r_k <= 1'b0;
                        r_i <= r_i + IDX_W'(r_stride);
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_norm < NORM_MIN || r_corr[CORR_W-1] || r_corr == '0) begin
                        r_score <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_sq_step <= 2'd0;
                        r_sq      <= '0;
                        r_state   <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_pp      <= mul_p;
                    r_sq      <= r_sq + sq_add;
                    r_sq_step <= r_sq_step + 2'd1;
                    if (r_sq_step == 2'd3) begin
                        r_rem     <= '0;
                        r_q       <= '0;
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem     <= q_bit ? NORM_W'(rem_sh - {1'b0, r_norm})
                                       : NORM_W'(rem_sh);
                    r_sq      <= r_sq << 1;
                    r_q       <= {r_q[SCORE_W-2:0], q_bit};
                    r_div_cnt <= r_div_cnt + DIVC_W'(1);
                    if (r_div_cnt == DIVC_W'(SQ_W - 1)) begin
                        r_score <= {r_q[SCORE_W-2:0], q_bit};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done  = (r_state == S_DONE);
    assign o_sts.score = r_score;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |=> !o_sts.done)
        else $error("score done held two cycles");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_state == S_IDLE)
        else $error("score started while busy");

endmodule

// ===== hw/rtl/wbos_ctrl.sv =====
module wbos_ctrl import wbos_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_search,
    input  logic [OFF_W-1:0] i_expected,
    input  logic [SF_W-1:0]  i_sf,
    input  logic [TF_W-1:0]  i_tf,
    input  logic             i_stereo,
    output logic             o_idle,
    output t_score_cmd       o_cmd,
    input  t_score_sts       i_sts,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [OFF_W-1:0] o_out_offset
);

    typedef enum logic [2:0] {
        C_IDLE, C_BASE, C_COARSE, C_REFINE, C_EXH, C_OUT
    } t_state;

    t_state              r_state;
    logic                r_wait;
    logic                r_start;
    logic                r_coarse;
    logic [OFF_W-1:0]    r_off;
    logic [OFF_W-1:0]    r_lo, r_hi;
    logic [SF_W-1:0]     r_sf;
    logic [TF_W-1:0]     r_tf;
    logic                r_stereo;
    logic [OFF_W-1:0]    r_top_o [TOP_COUNT];
    logic [SCORE_W-1:0]  r_top_s [TOP_COUNT];
    logic [USED_W-1:0]   r_used;
    logic [TOPI_W-1:0]   r_c;
    logic [OFF_W-1:0]    r_best_f;
    logic [SCORE_W-1:0]  r_best_v;
    logic                r_out_valid;
    logic [OFF_W-1:0]    r_out_offset;

    logic [SF_W-1:0]     sf_sat, max_off, lo_a, lo_v, hi_a, hi_v, clamp_v;
    logic [TF_W-1:0]     tf_sat;
    logic [USED_W-1:0]   at;
    logic                ins;
    logic [OFF_W-1:0]    n_top_o [TOP_COUNT];
    logic [SCORE_W-1:0]  n_top_s [TOP_COUNT];
    logic [USED_W-1:0]   n_used;
    logic                better;
    logic [TOPI_W-1:0]   c_next;
    logic [OFF_W-1:0]    rlo_cur, rhi_cur, rlo_next;

    function automatic logic [OFF_W-1:0] ref_lo(input logic [OFF_W-1:0] t,
                                                input logic [OFF_W-1:0] lo);
        logic [SF_W-1:0] lim;
        lim = SF_W'(lo) + SF_W'(COARSE_STRIDE - 1);
        ref_lo = (SF_W'(t) >= lim) ? OFF_W'(t - OFF_W'(COARSE_STRIDE - 1)) : lo;
    endfunction

    function automatic logic [OFF_W-1:0] ref_hi(input logic [OFF_W-1:0] t,
                                                input logic [OFF_W-1:0] hi);
        logic [SF_W-1:0] up;
        up = SF_W'(t) + SF_W'(COARSE_STRIDE - 1);
        ref_hi = (up > SF_W'(hi)) ? hi : OFF_W'(up);
    endfunction

    // window: expected +/- radius clamped to [0, max(0, frames - window)]
    always_comb begin
        sf_sat  = (i_sf > SF_W'(SOURCE_FRAMES)) ? SF_W'(SOURCE_FRAMES) : i_sf;
        tf_sat  = (i_tf > TF_W'(TAIL_CAP)) ? TF_W'(TAIL_CAP) : i_tf;
        max_off = (sf_sat >= SF_W'(WINDOW_FRAMES)) ? sf_sat - SF_W'(WINDOW_FRAMES)
                                                   : '0;
        lo_a    = (SF_W'(i_expected) >= SF_W'(SEARCH_RADIUS))
                  ? SF_W'(i_expected) - SF_W'(SEARCH_RADIUS) : '0;
        lo_v    = (lo_a > max_off) ? max_off : lo_a;
        hi_a    = SF_W'(i_expected) + SF_W'(SEARCH_RADIUS);
        hi_v    = (hi_a > max_off) ? max_off : hi_a;
        if (hi_v < lo_v) begin
            hi_v = lo_v;
        end
        clamp_v = SF_W'(i_expected);
        if (clamp_v < lo_v) begin
            clamp_v = lo_v;
        end else if (clamp_v > hi_v) begin
            clamp_v = hi_v;
        end
    end

    // candidate list insertion, ties to the smaller offset
    always_comb begin
        at = r_used;
        for (int i = TOP_COUNT - 1; i >= 0; i--) begin
            if (USED_W'(i) < r_used &&
                (i_sts.score > r_top_s[i] ||
                 (i_sts.score == r_top_s[i] && r_off < r_top_o[i]))) begin
                at = USED_W'(i);
            end
        end
        ins    = (i_sts.score != '0) && (at < USED_W'(TOP_COUNT));
        n_used = r_used;
        if (ins && r_used < USED_W'(TOP_COUNT)) begin
            n_used = r_used + USED_W'(1);
        end
        for (int i = 0; i < TOP_COUNT; i++) begin
            n_top_o[i] = r_top_o[i];
            n_top_s[i] = r_top_s[i];
            if (ins && USED_W'(i) == at) begin
                n_top_o[i] = r_off;
                n_top_s[i] = i_sts.score;
            end else if (ins && USED_W'(i) > at && i > 0) begin
                n_top_o[i] = r_top_o[(i > 0) ? i - 1 : 0];
                n_top_s[i] = r_top_s[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_comb begin
        better   = (i_sts.score > r_best_v) ||
                   (i_sts.score == r_best_v && i_sts.score != '0 && r_off < r_best_f);
        c_next   = r_c + TOPI_W'(1);
        rlo_cur  = ref_lo(r_top_o[r_c], r_lo);
        rhi_cur  = ref_hi(r_top_o[r_c], r_hi);
        rlo_next = ref_lo(r_top_o[c_next], r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_wait      <= 1'b0;
            r_start     <= 1'b0;
            r_used      <= '0;
            r_best_f    <= '0;
            r_best_v    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TOP_COUNT; i++) begin
                r_top_o[i] <= '0;
                r_top_s[i] <= '0;
            end
        end else begin
            // in C_OUT a taken result is replaced by the new one below
            if (r_out_valid && i_out_ready && r_state != C_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                C_IDLE: begin
                    if (i_search) begin
                        r_sf     <= sf_sat;
                        r_tf     <= tf_sat;
                        r_stereo <= i_stereo;
                        r_lo     <= OFF_W'(lo_v);
                        r_hi     <= OFF_W'(hi_v);
                        r_off    <= OFF_W'(clamp_v);
                        r_coarse <= 1'b0;
                        r_state  <= C_BASE;
                    end
                end
                C_BASE, C_COARSE, C_REFINE, C_EXH: begin
                    if (!r_wait) begin
                        r_start <= 1'b1;
                        r_wait  <= 1'b1;
                    end else begin
                        r_start <= 1'b0;
                        if (i_sts.done) begin
                            r_wait <= 1'b0;
                            case (r_state)
                                C_BASE: begin
                                    r_best_f <= r_off;
                                    r_best_v <= i_sts.score;
                                    r_used   <= '0;
                                    r_off    <= r_lo;
                                    r_coarse <= 1'b1;
                                    r_state  <= C_COARSE;
                                end
                                C_COARSE: begin
                                    for (int i = 0; i < TOP_COUNT; i++) begin
                                        r_top_o[i] <= n_top_o[i];
                                        r_top_s[i] <= n_top_s[i];
                                    end
                                    r_used <= n_used;
                                    if (r_off == r_hi) begin
                                        r_coarse <= 1'b0;
                                        r_c      <= '0;
                                        if (n_used == '0) begin
                                            r_off   <= r_lo;
                                            r_state <= C_EXH;
                                        end else begin
                                            r_off   <= ref_lo(n_top_o[0], r_lo);
                                            r_state <= C_REFINE;
                                        end
                                    end else begin
                                        r_off <= r_off + OFF_W'(1);
                                    end
                                end
                                C_REFINE: begin
                                    if (better) begin
                                        r_best_f <= r_off;
                                        r_best_v <= i_sts.score;
                                    end
                                    if (r_off >= rhi_cur) begin
                                        if (USED_W'(r_c) + USED_W'(1) >= r_used) begin
                                            r_state <= C_OUT;
                                        end else begin
                                            r_c   <= c_next;
                                            r_off <= rlo_next;
                                        end
                                    end else begin
                                        r_off <= r_off + OFF_W'(1);
                                    end
                                end
                                default: begin
                                    if (better) begin
                                        r_best_f <= r_off;
                                        r_best_v <= i_sts.score;
                                    end
                                    if (r_off == r_hi) begin
                                        r_state <= C_OUT;
                                    end else begin
                                        r_off <= r_off + OFF_W'(1);
                                    end
                                end
                            endcase
                        end
                    end
                end
                C_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_offset <= r_best_f;
                        r_state      <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_idle       = (r_state == C_IDLE);
    assign o_cmd.start  = r_start;
    assign o_cmd.off    = r_off;
    assign o_cmd.coarse = r_coarse;
    assign o_cmd.sf     = r_sf;
    assign o_cmd.tf     = r_tf;
    assign o_cmd.stereo = r_stereo;
    assign o_out_valid  = r_out_valid;
    assign o_out_offset = r_out_offset;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TOP_COUNT))
        else $error("candidate count overflow");

    a_best_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_REFINE || r_state == C_EXH || r_state == C_OUT) |->
        (r_best_f >= r_lo && r_best_f <= r_hi))
        else $error("best offset left the window");

    a_top_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_REFINE && r_used >= USED_W'(2)) |->
        r_top_s[0] >= r_top_s[1])
        else $error("candidate list out of order");

endmodule

// ===== hw/rtl/wsola_best_offset_search.sv =====
// channel   dir  fields                                         request moves
// i_in      in   mode frame_index channel_index sample          valid & ready
//                expected_offset source_frames tail_len
// o_out     out  best_offset                                    valid & ready
// i_cfg_*   in   channel_count (2 bits)                         write enable
//
// loads are accepted one request per cycle while no search runs
// a search scores each offset on one shared multiply-accumulate lane: sample
// reads with accumulation, then squaring by partial products, then bit-serial division
// the search covers the base offset, every window offset coarse, then the
// refine ranges (or the whole window again when no candidate scored)
// i_in.ready is low from a search request until its result is registered
// the result register lets loads continue while o_out is stalled
// reset is synchronous, active low; the sample stores are not cleared
module wsola_best_offset_search import wbos_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CC_W-1:0] i_cfg_wdata,
    wbos_in_if.sink         i_in,
    wbos_out_if.source      o_out
);

    logic [CC_W-1:0] r_channel_count;
    logic            accept;
    logic            ctrl_idle;
    t_load           load;
    t_score_cmd      cmd;
    t_score_sts      sts;

    // channel count: zero acts as mono, three as stereo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CC_RESET;
        end else if (i_cfg_we) begin
            r_channel_count <= i_cfg_wdata;
        end
    end

    assign i_in.ready = ctrl_idle;
    assign accept     = i_in.valid && i_in.ready;

    // load decode: tail frames wrap, source frames address the whole store
    assign load.tail_we   = accept && (i_in.mode == MODE_TAIL);
    assign load.src_we    = accept && (i_in.mode == MODE_SRC);
    assign load.tail_addr = {i_in.frame_index[TAIL_FW-1:0], i_in.channel_index};
    assign load.src_addr  = {i_in.frame_index, i_in.channel_index};
    assign load.data      = i_in.sample;

    wbos_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_search     (accept && (i_in.mode == MODE_SEARCH)),
        .i_expected   (i_in.expected_offset),
        .i_sf         (i_in.source_frames),
        .i_tf         (i_in.tail_len),
        .i_stereo     (r_channel_count[1]),
        .o_idle       (ctrl_idle),
        .o_cmd        (cmd),
        .i_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_offset (o_out.best_offset)
    );

    // score unit holds both sample stores and the correlation lane
    wbos_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
